### hw/rtl/serial_command_frame_decoder_defines.svh
// Assertion macros shared by the frame decoder RTL.
`ifndef SERIAL_COMMAND_FRAME_DECODER_DEFINES_SVH
`define SERIAL_COMMAND_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, checked on clk, off while arst_n is low.
`define SCFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off while arst_n is low.
`define SCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/scfd_pkg.sv
// Types, codes and keyword tables for the serial command frame decoder.
`timescale 1ns / 1ps

package scfd_pkg;

	// event codes
	localparam logic [1:0] EV_NONE       = 2'd0;
	localparam logic [1:0] EV_CONNECT    = 2'd1;
	localparam logic [1:0] EV_DISCONNECT = 2'd2;
	localparam logic [1:0] EV_EXAM       = 2'd3;

	// reply codes
	localparam logic [1:0] RP_NONE       = 2'd0;
	localparam logic [1:0] RP_CONNECT    = 2'd1;
	localparam logic [1:0] RP_DISCONNECT = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_START_SYM = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_SYM   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEP_SYM   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXAM_FRST = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXAM_NONE = 3'd4;

	// register reset values
	localparam logic [7:0] START_SYM_RST = 8'd36;
	localparam logic [7:0] END_SYM_RST   = 8'd35;
	localparam logic [7:0] SEP_SYM_RST   = 8'd58;
	localparam logic [7:0] EXAM_FRST_RST = 8'd0;
	localparam logic [7:0] EXAM_NONE_RST = 8'd3;

	// match flag bits
	localparam int unsigned MF_CONNECT    = 0;
	localparam int unsigned MF_DISCONNECT = 1;
	localparam int unsigned MF_EXAM       = 2;

	// number magnitude, saturating at NUM_CAP
	localparam int unsigned NUM_W = 9;
	localparam logic [NUM_W-1:0] NUM_CAP = 9'd256;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [1:0] reply_kind;
		logic       is_connected;
		logic [7:0] exam_type;
		logic       exam_led_on;
		logic       frame_overflow;
	} scfd_result_t;

	function automatic logic [7:0] kw_connect_chr(input logic [3:0] pos);
		logic [7:0] chr;
		case (pos)
			4'd0: chr = "C";
			4'd1: chr = "O";
			4'd2: chr = "N";
			4'd3: chr = "N";
			4'd4: chr = "E";
			4'd5: chr = "C";
			4'd6: chr = "T";
			default: chr = 8'd0;
		endcase
		return chr;
	endfunction

	function automatic logic [7:0] kw_disconnect_chr(input logic [3:0] pos);
		logic [7:0] chr;
		case (pos)
			4'd0: chr = "D";
			4'd1: chr = "I";
			4'd2: chr = "S";
			4'd3: chr = "C";
			4'd4: chr = "O";
			4'd5: chr = "N";
			4'd6: chr = "N";
			4'd7: chr = "E";
			4'd8: chr = "C";
			4'd9: chr = "T";
			default: chr = 8'd0;
		endcase
		return chr;
	endfunction

	function automatic logic [7:0] kw_exam_chr(input logic [1:0] pos);
		logic [7:0] chr;
		case (pos)
			2'd0: chr = "E";
			2'd1: chr = "X";
			2'd2: chr = "A";
			default: chr = "M";
		endcase
		return chr;
	endfunction

	// body ends: keep only keywords whose length fits the matched count
	function automatic logic [2:0] close_match(input logic [2:0] flags, input logic is7,
			input logic is10, input logic lt5);
		logic [2:0] f;
		f = flags;
		if (!is7) f[MF_CONNECT] = 1'b0;
		if (!is10) f[MF_DISCONNECT] = 1'b0;
		if (lt5) f[MF_EXAM] = 1'b0;
		return f;
	endfunction

endpackage

### hw/rtl/scfd_in_if.sv
// Received byte channel.
`timescale 1ns / 1ps

interface scfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

### hw/rtl/scfd_out_if.sv
// Frame result channel.
`timescale 1ns / 1ps

interface scfd_out_if
	import scfd_pkg::*;
;
	logic         valid;
	logic         ready;
	scfd_result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/serial_command_frame_decoder.sv
// Serial command frame decoder: byte matcher, session state and result register.
// A result is registered: the end symbol passes the byte register, then the result register.
// Throughput: one byte per cycle; the byte register stalls only while a result waits.
// The per-byte matcher and number parser are combinational and update their small registers per accepted byte.
// Reset (arst_n low, asynchronous): no frame open, disconnected, exam type 3, green LED,
// configuration registers back to their defaults, both pipeline registers empty.
`timescale 1ns / 1ps
`include "serial_command_frame_decoder_defines.svh"

module serial_command_frame_decoder
	import scfd_pkg::*;
#(
	parameter int unsigned MAX_BODY = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_wdata,
	scfd_in_if.sink              rx,
	scfd_out_if.source           report
);

	localparam int unsigned LEN_W = $clog2(MAX_BODY + 1);
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BODY);

	// number parser phases
	localparam logic [1:0] NP_SKIP   = 2'd0;
	localparam logic [1:0] NP_SIGN   = 2'd1;
	localparam logic [1:0] NP_DIGITS = 2'd2;
	localparam logic [1:0] NP_DONE   = 2'd3;

	// configuration
	logic [7:0] start_sym_q, end_sym_q, sep_sym_q, exam_frst_q, exam_none_q;

	// byte register
	logic       valid_s1;
	logic [7:0] rx_byte_s1;

	// frame and session state
	logic             in_frame_q, in_frame_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic             zero_seen_q, zero_seen_n;
	logic [2:0]       flags_q, flags_n;
	logic [1:0]       phase_q, phase_n;
	logic             neg_q, neg_n;
	logic [NUM_W-1:0] num_q, num_n;
	logic             conn_q, conn_n;
	logic [7:0]       exam_q, exam_n;
	logic             led_q, led_n;

	// result register
	logic         res_valid_q;
	scfd_result_t res_q, res_n;

	logic fire, step_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_sym_q <= START_SYM_RST;
			end_sym_q   <= END_SYM_RST;
			sep_sym_q   <= SEP_SYM_RST;
			exam_frst_q <= EXAM_FRST_RST;
			exam_none_q <= EXAM_NONE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_START_SYM: start_sym_q <= cfg_wdata;
				REG_END_SYM:   end_sym_q   <= cfg_wdata;
				REG_SEP_SYM:   sep_sym_q   <= cfg_wdata;
				REG_EXAM_FRST: exam_frst_q <= cfg_wdata;
				REG_EXAM_NONE: exam_none_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// per-byte matching, number parsing and frame end handling
	always_comb begin
		logic [7:0]  c;
		logic [2:0]  mf;
		logic        special;
		logic        digit, space;
		logic [1:0]  ph;
		logic [11:0] prod;
		logic        ok;
		logic [1:0]  ev;

		c       = rx_byte_s1;
		mf      = flags_q;
		special = 1'b0;
		digit   = (c >= "0") && (c <= "9");
		space   = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
		ph      = phase_q;
		prod    = '0;
		ok      = 1'b0;
		ev      = EV_NONE;

		in_frame_n  = in_frame_q;
		len_n       = len_q;
		zero_seen_n = zero_seen_q;
		flags_n     = flags_q;
		phase_n     = phase_q;
		neg_n       = neg_q;
		num_n       = num_q;
		conn_n      = conn_q;
		exam_n      = exam_q;
		led_n       = led_q;
		fire        = 1'b0;
		res_n       = '0;

		if (valid_s1) begin
			if (!in_frame_q) begin
				// waiting for a frame start
				if (c == start_sym_q) begin
					in_frame_n  = 1'b1;
					len_n       = '0;
					zero_seen_n = 1'b0;
					flags_n     = 3'b111;
					phase_n     = NP_SKIP;
					neg_n       = 1'b0;
					num_n       = '0;
				end
			end else if (c != end_sym_q) begin
				// body byte
				if (len_q < MAX_LEN) len_n = len_q + LEN_W'(1);
				if (!zero_seen_q && (len_q < MAX_LEN)) begin
					if ((len_q >= LEN_W'(7)) || (c != kw_connect_chr(len_q[3:0])))
						mf[MF_CONNECT] = 1'b0;
					if ((len_q >= LEN_W'(10)) || (c != kw_disconnect_chr(len_q[3:0])))
						mf[MF_DISCONNECT] = 1'b0;
					if (len_q < LEN_W'(4)) begin
						if (c != kw_exam_chr(len_q[1:0])) mf[MF_EXAM] = 1'b0;
					end else if (len_q == LEN_W'(4)) begin
						if (c != sep_sym_q) mf[MF_EXAM] = 1'b0;
					end

					if (c == 8'd0) begin
						// zero byte ends the body; a zero separator leaves an empty number
						zero_seen_n = 1'b1;
						special = (len_q == LEN_W'(4)) && (sep_sym_q == 8'd0);
						mf = close_match(mf, len_q == LEN_W'(7), len_q == LEN_W'(10),
							(len_q < LEN_W'(5)) && !special);
					end else if ((len_q >= LEN_W'(5)) && mf[MF_EXAM]) begin
						// atoi-style number
						if (ph == NP_SKIP) begin
							if (space) begin
								ph = NP_SKIP;
							end else if ((c == "+") || (c == "-")) begin
								neg_n = (c == "-");
								ph    = NP_SIGN;
							end else begin
								ph = digit ? NP_DIGITS : NP_DONE;
							end
							if (ph == NP_DIGITS) prod = 12'(num_q) * 12'd10 + 12'(c[3:0]);
						end else if (ph == NP_SIGN) begin
							ph = digit ? NP_DIGITS : NP_DONE;
							if (ph == NP_DIGITS) prod = 12'(num_q) * 12'd10 + 12'(c[3:0]);
						end else if (ph == NP_DIGITS) begin
							if (!digit) ph = NP_DONE;
							if (ph == NP_DIGITS) prod = 12'(num_q) * 12'd10 + 12'(c[3:0]);
						end
						if (ph == NP_DIGITS)
							num_n = (prod > 12'(NUM_CAP)) ? NUM_CAP : prod[NUM_W-1:0];
						phase_n = ph;
					end
					flags_n = mf;
				end
			end else begin
				// frame end: classify and update the session
				in_frame_n = 1'b0;
				fire       = 1'b1;
				if (len_q >= MAX_LEN) begin
					res_n.frame_overflow = 1'b1;
				end else begin
					if (!zero_seen_q)
						mf = close_match(flags_q, len_q == LEN_W'(7), len_q == LEN_W'(10),
							len_q < LEN_W'(5));
					if (mf[MF_CONNECT]) ev = EV_CONNECT;
					else if (mf[MF_DISCONNECT]) ev = EV_DISCONNECT;
					else if (mf[MF_EXAM]) ev = EV_EXAM;
				end

				res_n.reply_kind = RP_NONE;
				unique case (ev)
					EV_DISCONNECT: begin
						conn_n = 1'b0;
						exam_n = exam_none_q;
						led_n  = 1'b0;
						res_n.reply_kind = RP_DISCONNECT;
					end
					EV_CONNECT: begin
						if (!conn_q) begin
							conn_n = 1'b1;
							res_n.reply_kind = RP_CONNECT;
						end
					end
					EV_EXAM: begin
						if (neg_q && (num_q != '0)) ok = 1'b0;
						else ok = (num_q >= NUM_W'(exam_frst_q)) &&
							(num_q <= NUM_W'(exam_none_q));
						exam_n = ok ? num_q[7:0] : exam_none_q;
						if (conn_q) led_n = (exam_n != exam_none_q);
					end
					default: ;
				endcase

				len_n       = '0;
				zero_seen_n = 1'b0;
				flags_n     = 3'b111;
				phase_n     = NP_SKIP;
				neg_n       = 1'b0;
				num_n       = '0;

				res_n.event_kind   = ev;
				res_n.is_connected = conn_n;
				res_n.exam_type    = exam_n;
				res_n.exam_led_on  = led_n;
			end
		end
	end

	// a byte moves on unless it makes a result while the result register is full and not taken
	assign step_en  = valid_s1 && (!fire || !res_valid_q || report.ready);
	assign rx.ready = !valid_s1 || step_en;

	// byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready) rx_byte_s1 <= rx.rx_byte;
	end

	// frame and session state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			len_q       <= '0;
			zero_seen_q <= 1'b0;
			flags_q     <= 3'b111;
			phase_q     <= NP_SKIP;
			neg_q       <= 1'b0;
			num_q       <= '0;
			conn_q      <= 1'b0;
			exam_q      <= EXAM_NONE_RST;
			led_q       <= 1'b0;
		end else if (step_en) begin
			in_frame_q  <= in_frame_n;
			len_q       <= len_n;
			zero_seen_q <= zero_seen_n;
			flags_q     <= flags_n;
			phase_q     <= phase_n;
			neg_q       <= neg_n;
			num_q       <= num_n;
			conn_q      <= conn_n;
			exam_q      <= exam_n;
			led_q       <= led_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step_en && fire) begin
			res_valid_q <= 1'b1;
		end else if (report.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && fire) res_q <= res_n;
	end

	assign report.valid = res_valid_q;
	assign report.data  = res_q;

	// checks
	`SCFD_ASSERT_NOW(a_len_bound, 1'b1, len_q <= MAX_LEN, "body length above limit")
	`SCFD_ASSERT_NOW(a_ovf_no_event, res_valid_q && res_q.frame_overflow,
		res_q.event_kind == EV_NONE && res_q.reply_kind == RP_NONE,
		"overflowed frame reports an event")
	`SCFD_ASSERT_NOW(a_disc_reply, res_valid_q && res_q.event_kind == EV_DISCONNECT,
		!res_q.is_connected && res_q.reply_kind == RP_DISCONNECT && !res_q.exam_led_on,
		"disconnect result inconsistent")
	`SCFD_ASSERT_NEXT(a_byte_held, valid_s1 && !step_en, valid_s1 && $stable(rx_byte_s1),
		"stalled byte lost")

endmodule
